>>> rtl/core/cff_pkg.sv
// Package for the continued-fraction convergent block.
// Holds the parity codes and the back-end state type; no dependencies.
`timescale 1ns / 1ps

package cff_pkg;

  // Tangle class from the parities of numerator and denominator
  typedef enum logic [1:0] {
    PAR_ZERO    = 2'd0,
    PAR_ONE     = 2'd1,
    PAR_INF     = 2'd2,
    PAR_INVALID = 2'd3
  } parity_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_DONE
  } back_state_t;

endpackage

>>> rtl/core/cff_front.sv
// Front end: accepts twist entries and runs the convergent recurrence.
// Pushes the finished numerator and denominator into the fraction queue.
`timescale 1ns / 1ps

module cff_front #(
  parameter int VALUE_WIDTH = 16,
  parameter int TWIST_WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [TWIST_WIDTH-1:0]   twist_value,
  input  logic                     last_entry,
  output logic                     frac_push,
  output logic [2*VALUE_WIDTH-1:0] frac_data
);

  localparam int PW = VALUE_WIDTH + TWIST_WIDTH;

  logic [VALUE_WIDTH-1:0] num_current, num_previous, den_current, den_previous;
  logic [PW-1:0]          prod_p, prod_q;
  logic [VALUE_WIDTH-1:0] num_next, den_next;

  // Form the next convergent, wrapping at the value width
  always_comb begin
    prod_p   = {{VALUE_WIDTH{1'b0}}, twist_value} * {{TWIST_WIDTH{1'b0}}, num_current};
    prod_q   = {{VALUE_WIDTH{1'b0}}, twist_value} * {{TWIST_WIDTH{1'b0}}, den_current};
    num_next = prod_p[VALUE_WIDTH-1:0] + num_previous;
    den_next = prod_q[VALUE_WIDTH-1:0] + den_previous;
  end

  // Advance the recurrence; restart it after the last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      num_current  <= VALUE_WIDTH'(1);
      num_previous <= '0;
      den_current  <= '0;
      den_previous <= VALUE_WIDTH'(1);
    end else if (accept) begin
      if (last_entry) begin
        num_current  <= VALUE_WIDTH'(1);
        num_previous <= '0;
        den_current  <= '0;
        den_previous <= VALUE_WIDTH'(1);
      end else begin
        num_current  <= num_next;
        num_previous <= num_current;
        den_current  <= den_next;
        den_previous <= den_current;
      end
    end
  end

  // Hand the finished fraction to the queue
  assign frac_push = accept & last_entry;
  assign frac_data = {num_next, den_next};

endmodule

>>> rtl/core/cff_queue.sv
// Two-entry queue of finished fractions between front and back end.
// Stand-alone; no package use.
`timescale 1ns / 1ps

module cff_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             do_push, do_pop;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = slot[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/cff_back.sv
// Back end: bit-serial remainders of numerator and denominator, parity code,
// and the output register. Uses cff_pkg for the parity and state types.
`timescale 1ns / 1ps

module cff_back #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     frac_empty,
  input  logic [2*VALUE_WIDTH-1:0] frac_data,
  output logic                     frac_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic [VALUE_WIDTH-1:0]   numerator,
  output logic [VALUE_WIDTH-1:0]   denominator,
  output logic [VALUE_WIDTH-1:0]   num_mod_den,
  output logic [VALUE_WIDTH-1:0]   den_mod_num,
  output logic                     divide_by_zero,
  output logic [1:0]               parity_code
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  cff_pkg::back_state_t state, state_next;

  logic [VALUE_WIDTH-1:0] p_val, q_val;      // operands
  logic [VALUE_WIDTH-1:0] p_shift, q_shift;  // dividends, MSB first
  logic [VALUE_WIDTH-1:0] rem_p, rem_q;      // p mod q, q mod p
  logic [CW-1:0]          step;
  logic                   last_step;
  logic                   load, run, deliver;
  logic                   out_valid;

  logic [VALUE_WIDTH:0]   rem_p_sh, rem_q_sh, diff_p, diff_q;
  logic [VALUE_WIDTH-1:0] rem_p_next, rem_q_next;
  logic                   p_zero, q_zero;
  cff_pkg::parity_t       parity;

  assign last_step = step == CW'(VALUE_WIDTH - 1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cff_pkg::BK_IDLE:   if (!frac_empty) state_next = cff_pkg::BK_DIVIDE;
      cff_pkg::BK_DIVIDE: if (last_step) state_next = cff_pkg::BK_DONE;
      cff_pkg::BK_DONE:   if (!out_valid || pop) state_next = cff_pkg::BK_IDLE;
      default:            state_next = cff_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    load    = 1'b0;
    run     = 1'b0;
    deliver = 1'b0;
    unique case (state)
      cff_pkg::BK_IDLE:   load = ~frac_empty;
      cff_pkg::BK_DIVIDE: run = 1'b1;
      cff_pkg::BK_DONE:   deliver = ~out_valid | pop;
      default: ;
    endcase
  end

  assign frac_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cff_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One restoring step for each remainder
  always_comb begin
    rem_p_sh   = {rem_p, p_shift[VALUE_WIDTH-1]};
    rem_q_sh   = {rem_q, q_shift[VALUE_WIDTH-1]};
    diff_p     = rem_p_sh - {1'b0, q_val};
    diff_q     = rem_q_sh - {1'b0, p_val};
    rem_p_next = (rem_p_sh >= {1'b0, q_val}) ? diff_p[VALUE_WIDTH-1:0]
                                             : rem_p_sh[VALUE_WIDTH-1:0];
    rem_q_next = (rem_q_sh >= {1'b0, p_val}) ? diff_q[VALUE_WIDTH-1:0]
                                             : rem_q_sh[VALUE_WIDTH-1:0];
  end

  // Load operands and iterate one bit a cycle
  always_ff @(posedge clk) begin
    if (load) begin
      p_val   <= frac_data[2*VALUE_WIDTH-1:VALUE_WIDTH];
      q_val   <= frac_data[VALUE_WIDTH-1:0];
      p_shift <= frac_data[2*VALUE_WIDTH-1:VALUE_WIDTH];
      q_shift <= frac_data[VALUE_WIDTH-1:0];
      rem_p   <= '0;
      rem_q   <= '0;
      step    <= '0;
    end else if (run) begin
      p_shift <= {p_shift[VALUE_WIDTH-2:0], 1'b0};
      q_shift <= {q_shift[VALUE_WIDTH-2:0], 1'b0};
      rem_p   <= rem_p_next;
      rem_q   <= rem_q_next;
      step    <= step + CW'(1);
    end
  end

  // Classify zero divisors and parity
  always_comb begin
    p_zero = p_val == '0;
    q_zero = q_val == '0;
    priority if (!p_val[0] && !q_val[0]) parity = cff_pkg::PAR_INVALID;
    else if (p_val[0] && q_val[0])       parity = cff_pkg::PAR_ONE;
    else if (p_val[0])                   parity = cff_pkg::PAR_INF;
    else                                 parity = cff_pkg::PAR_ZERO;
  end

  // Hold the result word until it is popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (deliver) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      numerator      <= p_val;
      denominator    <= q_val;
      num_mod_den    <= q_zero ? '0 : rem_p;
      den_mod_num    <= p_zero ? '0 : rem_q;
      divide_by_zero <= p_zero | q_zero;
      parity_code    <= parity;
    end
  end

  assign empty = ~out_valid;

endmodule

>>> rtl/core/continued_fraction_fraction_parity.sv
// Continued-fraction convergent with remainders and tangle parity.
// The front end runs the convergent recurrence on each twist entry and
// queues finished fractions; the back end computes both remainders one
// bit per cycle and holds the result word for the receiver.
//
// Input channel: push with full. An entry is taken when push is high and
// full is low; an entry with last_entry set ends the vector and yields one
// result word, other entries yield none. Entries are taken one per cycle
// while the two-entry fraction queue has room.
// Result channel: empty with pop. The word on the result ports is valid
// while empty is low and leaves when pop is high.
// The back end takes one fraction at a time into the shared bit-serial
// remainder unit; the queue lets the front end go on taking entries.
// When the receiver stalls, the result word holds, the queue fills and then
// full rises. Reset restarts the recurrence at 0/1 and 1/0 and drops all
// queued fractions and results.
// Uses cff_pkg, cff_front, cff_queue and cff_back.
`timescale 1ns / 1ps

module continued_fraction_fraction_parity #(
  parameter int VALUE_WIDTH = 16,
  parameter int TWIST_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [TWIST_WIDTH-1:0] twist_value,
  input  logic                   last_entry,
  output logic                   empty,
  input  logic                   pop,
  output logic [VALUE_WIDTH-1:0] numerator,
  output logic [VALUE_WIDTH-1:0] denominator,
  output logic [VALUE_WIDTH-1:0] num_mod_den,
  output logic [VALUE_WIDTH-1:0] den_mod_num,
  output logic                   divide_by_zero,
  output logic [1:0]             parity_code
);

  logic                     accept;
  logic                     frac_push, frac_pop, frac_empty;
  logic [2*VALUE_WIDTH-1:0] frac_in, frac_out;

  assign accept = push & ~full;

  // Recurrence front end
  cff_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TWIST_WIDTH (TWIST_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .twist_value (twist_value),
    .last_entry  (last_entry),
    .frac_push   (frac_push),
    .frac_data   (frac_in)
  );

  // Decouple front and back
  cff_queue #(
    .WIDTH (2 * VALUE_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (frac_push),
    .push_data (frac_in),
    .full      (full),
    .pop       (frac_pop),
    .pop_data  (frac_out),
    .empty     (frac_empty)
  );

  // Remainder and parity back end
  cff_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .frac_empty     (frac_empty),
    .frac_data      (frac_out),
    .frac_pop       (frac_pop),
    .empty          (empty),
    .pop            (pop),
    .numerator      (numerator),
    .denominator    (denominator),
    .num_mod_den    (num_mod_den),
    .den_mod_num    (den_mod_num),
    .divide_by_zero (divide_by_zero),
    .parity_code    (parity_code)
  );

endmodule
